>>> sv/ssb_pkg.sv
// shared types, constants and segment lookup for the seven-segment command sequencer
package ssb_pkg;

  localparam int DIGIT_COUNT = 4;
  localparam int QUEUE_DEPTH = 4;
  localparam int ADDR_W      = 4;
  localparam int DATA_W      = 32;

  localparam logic [6:0] BLANK_CODE = 7'h7f;
  localparam logic [7:0] POINT_BIT  = 8'h80;
  localparam logic [7:0] ADDR_BASE  = 8'hc0;
  localparam logic [7:0] CTRL_BASE  = 8'h88;

  localparam logic [2:0] BRIGHTNESS_RESET = 3'd7;
  localparam logic [7:0] AUTO_CMD_RESET   = 8'h40;
  localparam logic [7:0] FIXED_CMD_RESET  = 8'h44;

  localparam int SEG_COUNT = 13;
  localparam logic [7:0] SEG_TABLE [SEG_COUNT] = '{
    8'h3f, 8'h06, 8'h5b, 8'h4f, 8'h66, 8'h6d, 8'h7d, 8'h07,
    8'h7f, 8'h6f, 8'h77, 8'h7c, 8'h40
  };

  typedef enum logic [2:0] {
    OP_SHOW_DIGIT = 3'd0,
    OP_SHOW_FOUR  = 3'd1,
    OP_CLEAR      = 3'd2,
    OP_ZEROS      = 3'd3,
    OP_POINT      = 3'd4,
    OP_SET_BLINK  = 3'd5,
    OP_BLINK_TICK = 3'd6
  } op_e;

  typedef enum logic [1:0] {
    BLINK_NONE    = 2'd0,
    BLINK_ALL     = 2'd1,
    BLINK_PAIR_LO = 2'd2,
    BLINK_PAIR_HI = 2'd3
  } blink_e;

  typedef enum logic [1:0] {
    REG_BRIGHTNESS = 2'd0,
    REG_AUTO_CMD   = 2'd1,
    REG_FIXED_CMD  = 2'd2
  } reg_e;

  // one bus job: either a four-digit write or a run of single-digit writes
  typedef struct packed {
    logic                            four;
    logic [1:0]                      first_pos;
    logic [1:0]                      last_idx;
    logic [DIGIT_COUNT-1:0][7:0]     segs;
  } job_t;

  function automatic logic [7:0] seg_single(input logic [6:0] code, input logic pt);
    logic [7:0] pb;
    pb = pt ? POINT_BIT : 8'h00;
    if (code < 7'(SEG_COUNT)) return SEG_TABLE[code[3:0]] | pb;
    return pb;
  endfunction

  function automatic logic [7:0] seg_multi(input logic [6:0] code, input logic pt);
    logic [7:0] pb;
    pb = pt ? POINT_BIT : 8'h00;
    if (code < 7'(SEG_COUNT)) return SEG_TABLE[code[3:0]] | pb;
    return 8'h00;
  endfunction

endpackage

>>> sv/ssb_front.sv
// front end: takes requests, keeps display state and builds bus jobs
module ssb_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  input  logic [2:0]           operation_i,
  input  logic [1:0]           position_i,
  input  logic [6:0]           digit_zero_i,
  input  logic [6:0]           digit_one_i,
  input  logic [6:0]           digit_two_i,
  input  logic [6:0]           digit_three_i,
  input  logic                 save_digits_i,
  input  logic                 point_command_i,
  input  logic [1:0]           blink_choice_i,
  output logic                 stall_o,
  input  logic                 full_i,
  output logic                 push_o,
  output ssb_pkg::job_t        job_o
);

  logic [ssb_pkg::DIGIT_COUNT-1:0][6:0] saved_q, saved_d;
  logic [ssb_pkg::DIGIT_COUNT-1:0][6:0] codes;
  logic                                 point_q, point_d;
  ssb_pkg::blink_e                      mode_q, mode_d;
  logic                                 phase_q, phase_d;
  logic                                 accept;
  ssb_pkg::blink_e                      choice;
  logic [1:0]                           base;

  assign stall_o = full_i;
  assign accept  = valid_i & ~full_i;
  assign codes   = {digit_three_i, digit_two_i, digit_one_i, digit_zero_i};
  assign choice  = ssb_pkg::blink_e'(blink_choice_i);
  assign base    = (mode_q == ssb_pkg::BLINK_PAIR_LO) ? 2'd2 : 2'd0;

  always_comb begin
    saved_d = saved_q;
    point_d = point_q;
    mode_d  = mode_q;
    phase_d = phase_q;
    push_o  = 1'b0;
    job_o   = '0;
    if (accept) begin
      unique case (ssb_pkg::op_e'(operation_i))
        ssb_pkg::OP_SHOW_DIGIT: begin
          push_o          = 1'b1;
          job_o.first_pos = position_i;
          job_o.segs[0]   = ssb_pkg::seg_single(codes[0], point_q);
          if (save_digits_i) saved_d[position_i] = codes[0];
        end
        ssb_pkg::OP_SHOW_FOUR: begin
          push_o     = 1'b1;
          job_o.four = 1'b1;
          for (int k = 0; k < ssb_pkg::DIGIT_COUNT; k++) begin
            job_o.segs[k] = ssb_pkg::seg_multi(codes[k], point_q);
          end
          if (save_digits_i) saved_d = codes;
        end
        ssb_pkg::OP_CLEAR: begin
          push_o         = 1'b1;
          job_o.last_idx = 2'd3;
          for (int k = 0; k < ssb_pkg::DIGIT_COUNT; k++) begin
            job_o.segs[k] = ssb_pkg::seg_single(ssb_pkg::BLANK_CODE, point_q);
          end
        end
        ssb_pkg::OP_ZEROS: begin
          push_o         = 1'b1;
          job_o.last_idx = 2'd3;
          for (int k = 0; k < ssb_pkg::DIGIT_COUNT; k++) begin
            job_o.segs[k] = ssb_pkg::seg_single(7'd0, point_q);
          end
          if (save_digits_i) saved_d = '0;
        end
        ssb_pkg::OP_POINT: begin
          point_d = point_command_i | ~point_q;
        end
        ssb_pkg::OP_SET_BLINK: begin
          if (choice != mode_q) begin
            mode_d     = choice;
            push_o     = 1'b1;
            job_o.four = 1'b1;
            for (int k = 0; k < ssb_pkg::DIGIT_COUNT; k++) begin
              job_o.segs[k] = ssb_pkg::seg_multi(saved_q[k], point_q);
            end
            if (choice != ssb_pkg::BLINK_NONE) phase_d = 1'b1;
          end
        end
        ssb_pkg::OP_BLINK_TICK: begin
          unique case (mode_q)
            ssb_pkg::BLINK_PAIR_LO, ssb_pkg::BLINK_PAIR_HI: begin
              push_o          = 1'b1;
              job_o.first_pos = base;
              job_o.last_idx  = 2'd1;
              for (int k = 0; k < 2; k++) begin
                job_o.segs[k] = phase_q ?
                    ssb_pkg::seg_single(ssb_pkg::BLANK_CODE, point_q) :
                    ssb_pkg::seg_single(saved_q[2'(base + 2'(k))], point_q);
              end
              phase_d = ~phase_q;
            end
            ssb_pkg::BLINK_ALL: begin
              push_o = 1'b1;
              if (phase_q) begin
                job_o.last_idx = 2'd3;
                for (int k = 0; k < ssb_pkg::DIGIT_COUNT; k++) begin
                  job_o.segs[k] = ssb_pkg::seg_single(ssb_pkg::BLANK_CODE, point_q);
                end
                point_d = 1'b1;
              end else begin
                job_o.four = 1'b1;
                for (int k = 0; k < ssb_pkg::DIGIT_COUNT; k++) begin
                  job_o.segs[k] = ssb_pkg::seg_multi(saved_q[k], point_q);
                end
                point_d = 1'b0;
              end
              phase_d = ~phase_q;
            end
            ssb_pkg::BLINK_NONE: begin
            end
            default: begin
            end
          endcase
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      saved_q <= '0;
      point_q <= 1'b0;
      mode_q  <= ssb_pkg::BLINK_NONE;
      phase_q <= 1'b0;
    end else begin
      saved_q <= saved_d;
      point_q <= point_d;
      mode_q  <= mode_d;
      phase_q <= phase_d;
    end
  end

endmodule

>>> sv/ssb_fifo.sv
// short job queue between the front end and the byte sequencer
module ssb_fifo #(
  parameter int DEPTH = ssb_pkg::QUEUE_DEPTH
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  ssb_pkg::job_t data_i,
  output logic          full_o,
  input  logic          pop_i,
  output ssb_pkg::job_t data_o,
  output logic          empty_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  ssb_pkg::job_t mem [DEPTH];
  logic [PTR_W-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic do_push, do_pop;

  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;
  assign data_o  = mem[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) wr_d = (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
    if (do_pop)  rd_d = (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
    if (do_push && !do_pop) cnt_d = cnt_q + 1'b1;
    else if (!do_push && do_pop) cnt_d = cnt_q - 1'b1;
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem[wr_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

>>> sv/ssb_back.sv
// back end: walks a job byte by byte into the output register
module ssb_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic [2:0]    brightness_i,
  input  logic [7:0]    auto_cmd_i,
  input  logic [7:0]    fixed_cmd_i,
  input  ssb_pkg::job_t job_i,
  input  logic          empty_i,
  output logic          pop_o,
  output logic          busy_o,
  output logic          valid_o,
  input  logic          stall_i,
  output logic [7:0]    bus_byte_o,
  output logic          frame_start_o,
  output logic          frame_stop_o,
  output logic          last_o
);

  ssb_pkg::job_t job_q;
  logic          busy_q, busy_d;
  logic [1:0]    wr_q, wr_d;
  logic [2:0]    bt_q, bt_d;
  logic          out_valid_q;
  logic [7:0]    byte_q;
  logic          start_q, stop_q, last_q;
  logic          take, adv, load;
  logic [7:0]    cur_byte, ctrl_byte;
  logic          cur_start, cur_stop, cur_last;

  assign take      = ~out_valid_q | ~stall_i;
  assign adv       = busy_q & take;
  assign load      = ~empty_i & (~busy_q | (adv & cur_last));
  assign pop_o     = load;
  assign busy_o    = busy_q;
  assign ctrl_byte = ssb_pkg::CTRL_BASE + {5'b0, brightness_i};

  always_comb begin
    cur_byte  = ctrl_byte;
    cur_start = 1'b1;
    cur_stop  = 1'b1;
    cur_last  = 1'b0;
    if (job_q.four) begin
      unique case (bt_q)
        3'd0: cur_byte = auto_cmd_i;
        3'd1: begin
          cur_byte = ssb_pkg::ADDR_BASE;
          cur_stop = 1'b0;
        end
        3'd2, 3'd3, 3'd4, 3'd5: begin
          cur_byte  = job_q.segs[2'(bt_q - 3'd2)];
          cur_start = 1'b0;
          cur_stop  = (bt_q == 3'd5);
        end
        3'd6: cur_last = 1'b1;
        default: begin
        end
      endcase
    end else begin
      unique case (bt_q)
        3'd0: cur_byte = fixed_cmd_i;
        3'd1: begin
          cur_byte = ssb_pkg::ADDR_BASE | {6'b0, 2'(job_q.first_pos + wr_q)};
          cur_stop = 1'b0;
        end
        3'd2: begin
          cur_byte  = job_q.segs[wr_q];
          cur_start = 1'b0;
        end
        3'd3: cur_last = (wr_q == job_q.last_idx);
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    busy_d = busy_q;
    wr_d   = wr_q;
    bt_d   = bt_q;
    if (load) begin
      busy_d = 1'b1;
      wr_d   = '0;
      bt_d   = '0;
    end else if (adv) begin
      if (cur_last) begin
        busy_d = 1'b0;
      end else if (!job_q.four && bt_q == 3'd3) begin
        bt_d = '0;
        wr_d = wr_q + 1'b1;
      end else begin
        bt_d = bt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      wr_q        <= '0;
      bt_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      wr_q   <= wr_d;
      bt_q   <= bt_d;
      if (take) out_valid_q <= adv;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) job_q <= job_i;
    if (adv) begin
      byte_q  <= cur_byte;
      start_q <= cur_start;
      stop_q  <= cur_stop;
      last_q  <= cur_last;
    end
  end

  assign valid_o       = out_valid_q;
  assign bus_byte_o    = byte_q;
  assign frame_start_o = start_q;
  assign frame_stop_o  = stop_q;
  assign last_o        = last_q;

endmodule

>>> sv/seven_segment_blink_command_sequencer.sv
// top level: register port, front end, job queue and byte sequencer
// the first byte of a request passes through the job queue and the job register into the output register
// the byte sequencer then sends one byte per cycle while out_stall_i is low: 4, 7, 8 or 16
// bytes per request; a queued job loads with the last byte of the one before, so a busy
// stream runs on without a gap between requests
// reset clears the display state and loads the register reset values, no clearing pass
module seven_segment_blink_command_sequencer #(
  parameter int QUEUE_DEPTH = ssb_pkg::QUEUE_DEPTH
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [ssb_pkg::ADDR_W-1:0] paddr,
  input  logic [ssb_pkg::DATA_W-1:0] pwdata,
  output logic [ssb_pkg::DATA_W-1:0] prdata,
  output logic                       pready,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [2:0]                 operation_i,
  input  logic [1:0]                 position_i,
  input  logic [6:0]                 digit_zero_i,
  input  logic [6:0]                 digit_one_i,
  input  logic [6:0]                 digit_two_i,
  input  logic [6:0]                 digit_three_i,
  input  logic                       save_digits_i,
  input  logic                       point_command_i,
  input  logic [1:0]                 blink_choice_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [7:0]                 bus_byte_o,
  output logic                       frame_start_o,
  output logic                       frame_stop_o,
  output logic                       last_o
);

  logic [2:0]    bright_q;
  logic [7:0]    auto_q, fixed_q;
  logic          cfg_wr;
  ssb_pkg::reg_e reg_sel;

  logic          q_full, q_empty, q_push, q_pop, back_busy;
  ssb_pkg::job_t push_job, head_job;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign reg_sel = ssb_pkg::reg_e'(paddr[3:2]);

  always_comb begin
    unique case (reg_sel)
      ssb_pkg::REG_BRIGHTNESS: prdata = {29'b0, bright_q};
      ssb_pkg::REG_AUTO_CMD:   prdata = {24'b0, auto_q};
      ssb_pkg::REG_FIXED_CMD:  prdata = {24'b0, fixed_q};
      default:                 prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bright_q <= ssb_pkg::BRIGHTNESS_RESET;
      auto_q   <= ssb_pkg::AUTO_CMD_RESET;
      fixed_q  <= ssb_pkg::FIXED_CMD_RESET;
    end else if (cfg_wr) begin
      unique case (reg_sel)
        ssb_pkg::REG_BRIGHTNESS: bright_q <= pwdata[2:0];
        ssb_pkg::REG_AUTO_CMD:   auto_q   <= pwdata[7:0];
        ssb_pkg::REG_FIXED_CMD:  fixed_q  <= pwdata[7:0];
        default: begin
        end
      endcase
    end
  end

  ssb_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .valid_i         (in_valid_i),
    .operation_i     (operation_i),
    .position_i      (position_i),
    .digit_zero_i    (digit_zero_i),
    .digit_one_i     (digit_one_i),
    .digit_two_i     (digit_two_i),
    .digit_three_i   (digit_three_i),
    .save_digits_i   (save_digits_i),
    .point_command_i (point_command_i),
    .blink_choice_i  (blink_choice_i),
    .stall_o         (in_stall_o),
    .full_i          (q_full),
    .push_o          (q_push),
    .job_o           (push_job)
  );

  ssb_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (push_job),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .data_o  (head_job),
    .empty_o (q_empty)
  );

  ssb_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .brightness_i  (bright_q),
    .auto_cmd_i    (auto_q),
    .fixed_cmd_i   (fixed_q),
    .job_i         (head_job),
    .empty_i       (q_empty),
    .pop_o         (q_pop),
    .busy_o        (back_busy),
    .valid_o       (out_valid_o),
    .stall_i       (out_stall_i),
    .bus_byte_o    (bus_byte_o),
    .frame_start_o (frame_start_o),
    .frame_stop_o  (frame_stop_o),
    .last_o        (last_o)
  );

  // every request that sends bytes ends on the display control byte
  a_last_is_ctrl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && last_o |-> bus_byte_o == (ssb_pkg::CTRL_BASE + {5'b0, bright_q}))
    else $error("last byte is not display control");

  // a byte opened by start but not closed by stop is always an address byte
  a_addr_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && frame_start_o && !frame_stop_o |-> bus_byte_o[7:6] == 2'b11)
    else $error("open frame byte is not an address");

  // a full queue means the sequencer is working on a job
  a_full_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_full |-> back_busy)
    else $error("queue full while sequencer idle");

endmodule

>>> tb/tb_seven_segment_blink_command_sequencer.sv
// testbench for the seven-segment command sequencer: random requests, byte-level scoreboard
`timescale 1ns / 1ps

module tb_seven_segment_blink_command_sequencer;

  localparam logic [2:0] OP_UNDEFINED = 3'd7;
  localparam int QUIET_LIMIT = 2000;
  localparam int SETTLE_CYCLES = 12;

  typedef struct packed {
    logic [7:0] data;
    logic       start;
    logic       stop;
    logic       last;
  } bus_beat_t;

  // predicts the bus bytes of each request and checks them in order
  class display_scoreboard;
    bus_beat_t        expected_beats[$];
    int               errors;
    logic [3:0][6:0]  saved_code;
    logic             point_lit;
    ssb_pkg::blink_e  blink_mode;
    logic             blink_lit;
    logic [2:0]       brightness;
    logic [7:0]       auto_cmd;
    logic [7:0]       fixed_cmd;

    function new();
      errors     = 0;
      saved_code = '0;
      point_lit  = 1'b0;
      blink_mode = ssb_pkg::BLINK_NONE;
      blink_lit  = 1'b0;
      brightness = ssb_pkg::BRIGHTNESS_RESET;
      auto_cmd   = ssb_pkg::AUTO_CMD_RESET;
      fixed_cmd  = ssb_pkg::FIXED_CMD_RESET;
    endfunction

    function void set_register(ssb_pkg::reg_e idx, logic [31:0] val);
      case (idx)
        ssb_pkg::REG_BRIGHTNESS: brightness = val[2:0];
        ssb_pkg::REG_AUTO_CMD:   auto_cmd = val[7:0];
        ssb_pkg::REG_FIXED_CMD:  fixed_cmd = val[7:0];
        default: ;
      endcase
    endfunction

    // unknown codes keep the point bit on single writes, go dark on four-digit writes
    function logic [7:0] segments(logic [6:0] code, bit keep_point);
      logic [7:0] pt;
      pt = point_lit ? ssb_pkg::POINT_BIT : 8'h00;
      if (code < 7'(ssb_pkg::SEG_COUNT)) return ssb_pkg::SEG_TABLE[code[3:0]] | pt;
      return keep_point ? pt : 8'h00;
    endfunction

    function void emit(logic [7:0] data, logic start, logic stop);
      bus_beat_t b;
      b.data  = data;
      b.start = start;
      b.stop  = stop;
      b.last  = 1'b0;
      expected_beats.push_back(b);
    endfunction

    function void single_digit(logic [1:0] pos, logic [6:0] code);
      emit(fixed_cmd, 1'b1, 1'b1);
      emit(ssb_pkg::ADDR_BASE | {6'd0, pos}, 1'b1, 1'b0);
      emit(segments(code, 1'b1), 1'b0, 1'b1);
      emit(ssb_pkg::CTRL_BASE + {5'd0, brightness}, 1'b1, 1'b1);
    endfunction

    function void four_digits(logic [3:0][6:0] codes);
      emit(auto_cmd, 1'b1, 1'b1);
      emit(ssb_pkg::ADDR_BASE, 1'b1, 1'b0);
      for (int i = 0; i < ssb_pkg::DIGIT_COUNT; i++)
        emit(segments(codes[i], 1'b0), 1'b0, i == ssb_pkg::DIGIT_COUNT - 1);
      emit(ssb_pkg::CTRL_BASE + {5'd0, brightness}, 1'b1, 1'b1);
    endfunction

    function void blank_all();
      for (int p = 0; p < ssb_pkg::DIGIT_COUNT; p++) single_digit(2'(p), ssb_pkg::BLANK_CODE);
    endfunction

    function void note_request(logic [2:0] op, logic [1:0] pos, logic [3:0][6:0] codes,
                               logic save, logic pcmd, ssb_pkg::blink_e choice);
      int first;
      int base;
      first = expected_beats.size();
      case (op)
        ssb_pkg::OP_SHOW_DIGIT: begin
          single_digit(pos, codes[0]);
          if (save) saved_code[pos] = codes[0];
        end
        ssb_pkg::OP_SHOW_FOUR: begin
          if (save) saved_code = codes;
          four_digits(codes);
        end
        ssb_pkg::OP_CLEAR: blank_all();
        ssb_pkg::OP_ZEROS: begin
          for (int p = 0; p < ssb_pkg::DIGIT_COUNT; p++) single_digit(2'(p), 7'd0);
          if (save) saved_code = '0;
        end
        ssb_pkg::OP_POINT: point_lit = pcmd ? 1'b1 : ~point_lit;
        ssb_pkg::OP_SET_BLINK: begin
          if (choice != blink_mode) begin
            blink_mode = choice;
            four_digits(saved_code);
            if (choice != ssb_pkg::BLINK_NONE) blink_lit = 1'b1;
          end
        end
        ssb_pkg::OP_BLINK_TICK: begin
          if (blink_mode == ssb_pkg::BLINK_PAIR_LO || blink_mode == ssb_pkg::BLINK_PAIR_HI) begin
            base = (blink_mode == ssb_pkg::BLINK_PAIR_LO) ? 2 : 0;
            for (int p = base; p < base + 2; p++)
              single_digit(2'(p), blink_lit ? ssb_pkg::BLANK_CODE : saved_code[2'(p)]);
            blink_lit = ~blink_lit;
          end else if (blink_mode == ssb_pkg::BLINK_ALL) begin
            if (blink_lit) begin
              blank_all();
              point_lit = 1'b1;
            end else begin
              four_digits(saved_code);
              point_lit = 1'b0;
            end
            blink_lit = ~blink_lit;
          end
        end
        default: ;
      endcase
      if (expected_beats.size() > first) expected_beats[expected_beats.size() - 1].last = 1'b1;
    endfunction

    function void report(string field, logic [7:0] want, logic [7:0] got);
      errors++;
      $display("%0t: %s mismatch, expected %02h, actual %02h", $time, field, want, got);
    endfunction

    function void check_beat(bus_beat_t got);
      bus_beat_t want;
      if (expected_beats.size() == 0) begin
        errors++;
        $display("%0t: unexpected byte, expected none, actual %02h start %0b stop %0b last %0b",
                 $time, got.data, got.start, got.stop, got.last);
        return;
      end
      want = expected_beats.pop_front();
      if (got.data !== want.data) report("bus_byte", want.data, got.data);
      if (got.start !== want.start) report("frame_start", {7'd0, want.start}, {7'd0, got.start});
      if (got.stop !== want.stop) report("frame_stop", {7'd0, want.stop}, {7'd0, got.stop});
      if (got.last !== want.last) report("last", {7'd0, want.last}, {7'd0, got.last});
    endfunction
  endclass

  logic                       clk;
  logic                       rst_ni;
  logic                       psel, penable, pwrite;
  logic [ssb_pkg::ADDR_W-1:0] paddr;
  logic [ssb_pkg::DATA_W-1:0] pwdata, prdata;
  logic                       pready;
  logic                       in_valid_i, in_stall_o;
  logic [2:0]                 operation_i;
  logic [1:0]                 position_i;
  logic [6:0]                 digit_zero_i, digit_one_i, digit_two_i, digit_three_i;
  logic                       save_digits_i, point_command_i;
  logic [1:0]                 blink_choice_i;
  logic                       out_valid_o, out_stall_i;
  logic [7:0]                 bus_byte_o;
  logic                       frame_start_o, frame_stop_o, last_o;

  display_scoreboard sb;
  bit  send_gaps;
  bit  recv_stalls;
  int  quiet_cycles = 0;

  seven_segment_blink_command_sequencer u_top (
    .clk_i          (clk),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .operation_i    (operation_i),
    .position_i     (position_i),
    .digit_zero_i   (digit_zero_i),
    .digit_one_i    (digit_one_i),
    .digit_two_i    (digit_two_i),
    .digit_three_i  (digit_three_i),
    .save_digits_i  (save_digits_i),
    .point_command_i(point_command_i),
    .blink_choice_i (blink_choice_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .bus_byte_o     (bus_byte_o),
    .frame_start_o  (frame_start_o),
    .frame_stop_o   (frame_stop_o),
    .last_o         (last_o)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // monitors: requests in, bytes out, and a watchdog on quiet cycles
  always @(posedge clk) begin
    if (rst_ni && in_valid_i && !in_stall_o)
      sb.note_request(operation_i, position_i,
                      {digit_three_i, digit_two_i, digit_one_i, digit_zero_i},
                      save_digits_i, point_command_i, ssb_pkg::blink_e'(blink_choice_i));
    if (rst_ni && out_valid_o && !out_stall_i)
      sb.check_beat({bus_byte_o, frame_start_o, frame_stop_o, last_o});
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: timeout, %0d bytes still expected", $time, sb.expected_beats.size());
      $display("tb_seven_segment_blink_command_sequencer: done, errors");
      $finish;
    end
  end

  // the receiver stalls in bursts of random length while recv_stalls is set
  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk);
      if (recv_stalls && $urandom_range(0, 5) == 0) begin
        out_stall_i = 1'b1;
        repeat ($urandom_range(0, 10)) @(negedge clk);
        out_stall_i = 1'b0;
      end
    end
  end

  // called at a falling edge, returns at a falling edge
  task automatic write_reg(ssb_pkg::reg_e idx, logic [31:0] val);
    psel    = 1'b1;
    pwrite  = 1'b1;
    penable = 1'b0;
    paddr   = ssb_pkg::ADDR_W'(idx) << 2;
    pwdata  = val;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    sb.set_register(idx, val);
  endtask

  task automatic send_request(logic [2:0] op, logic [1:0] pos, logic [6:0] d0, logic [6:0] d1,
                              logic [6:0] d2, logic [6:0] d3, logic save, logic pcmd,
                              logic [1:0] choice);
    if (send_gaps && $urandom_range(0, 4) == 0) begin
      in_valid_i = 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clk);
    end
    operation_i     = op;
    position_i      = pos;
    digit_zero_i    = d0;
    digit_one_i     = d1;
    digit_two_i     = d2;
    digit_three_i   = d3;
    save_digits_i   = save;
    point_command_i = pcmd;
    blink_choice_i  = choice;
    in_valid_i      = 1'b1;
    do @(posedge clk); while (in_stall_o);
    @(negedge clk);
  endtask

  // mostly displayable codes, sometimes blank, sometimes any 7-bit value
  function automatic logic [6:0] pick_code();
    int r;
    r = $urandom_range(0, 9);
    if (r < 6) return 7'($urandom_range(0, 12));
    if (r == 6) return ssb_pkg::BLANK_CODE;
    return 7'($urandom_range(0, 127));
  endfunction

  task automatic send_random_request();
    int r;
    logic [2:0] op;
    r = $urandom_range(0, 99);
    if (r < 20)      op = ssb_pkg::OP_SHOW_DIGIT;
    else if (r < 35) op = ssb_pkg::OP_SHOW_FOUR;
    else if (r < 42) op = ssb_pkg::OP_CLEAR;
    else if (r < 49) op = ssb_pkg::OP_ZEROS;
    else if (r < 59) op = ssb_pkg::OP_POINT;
    else if (r < 72) op = ssb_pkg::OP_SET_BLINK;
    else if (r < 97) op = ssb_pkg::OP_BLINK_TICK;
    else             op = OP_UNDEFINED;
    send_request(op, 2'($urandom_range(0, 3)), pick_code(), pick_code(), pick_code(),
                 pick_code(), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                 2'($urandom_range(0, 3)));
  endtask

  // lets the queue empty, then waits out requests that produce no bytes
  task automatic wait_idle();
    in_valid_i = 1'b0;
    while (sb.expected_beats.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  initial begin
    logic [7:0] auto_v, fixed_v;
    logic [2:0] bright_v;
    sb              = new();
    send_gaps       = 1'b1;
    recv_stalls     = 1'b1;
    rst_ni          = 1'b0;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    in_valid_i      = 1'b0;
    operation_i     = ssb_pkg::OP_SHOW_DIGIT;
    position_i      = '0;
    digit_zero_i    = '0;
    digit_one_i     = '0;
    digit_two_i     = '0;
    digit_three_i   = '0;
    save_digits_i   = 1'b0;
    point_command_i = 1'b0;
    blink_choice_i  = ssb_pkg::BLINK_NONE;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_ni = 1'b1;
    @(negedge clk);

    // directed requests under reset register values
    send_request(ssb_pkg::OP_SHOW_DIGIT, 2'd0, 7'd0, 7'd0, 7'd0, 7'd0, 1'b1, 1'b0,
                 ssb_pkg::BLINK_NONE);
    send_request(ssb_pkg::OP_SHOW_DIGIT, 2'd3, 7'd12, 7'd0, 7'd0, 7'd0, 1'b1, 1'b0,
                 ssb_pkg::BLINK_NONE);
    send_request(ssb_pkg::OP_SHOW_DIGIT, 2'd1, 7'd13, 7'd0, 7'd0, 7'd0, 1'b0, 1'b0,
                 ssb_pkg::BLINK_NONE);
    send_request(ssb_pkg::OP_SHOW_DIGIT, 2'd2, ssb_pkg::BLANK_CODE, 7'd0, 7'd0, 7'd0, 1'b1,
                 1'b0, ssb_pkg::BLINK_NONE);
    send_request(ssb_pkg::OP_POINT, 2'd0, 7'd0, 7'd0, 7'd0, 7'd0, 1'b0, 1'b1,
                 ssb_pkg::BLINK_NONE);
    send_request(ssb_pkg::OP_SHOW_DIGIT, 2'd2, ssb_pkg::BLANK_CODE, 7'd0, 7'd0, 7'd0, 1'b0,
                 1'b0, ssb_pkg::BLINK_NONE);
    send_request(ssb_pkg::OP_SHOW_FOUR, 2'd0, 7'd8, 7'd9, 7'd10, 7'd11, 1'b1, 1'b0,
                 ssb_pkg::BLINK_NONE);
    send_request(ssb_pkg::OP_SHOW_FOUR, 2'd3, ssb_pkg::BLANK_CODE, 7'd13, 7'd100, 7'd0, 1'b0,
                 1'b0, ssb_pkg::BLINK_NONE);
    send_request(ssb_pkg::OP_POINT, 2'd0, 7'd0, 7'd0, 7'd0, 7'd0, 1'b0, 1'b0,
                 ssb_pkg::BLINK_NONE);
    send_request(ssb_pkg::OP_ZEROS, 2'd0, 7'd5, 7'd5, 7'd5, 7'd5, 1'b0, 1'b0,
                 ssb_pkg::BLINK_NONE);
    send_request(ssb_pkg::OP_CLEAR, 2'd0, 7'd0, 7'd0, 7'd0, 7'd0, 1'b1, 1'b0,
                 ssb_pkg::BLINK_NONE);
    // pair blinking, repeated mode, then blink all through both phases
    send_request(ssb_pkg::OP_SET_BLINK, 2'd0, 7'd0, 7'd0, 7'd0, 7'd0, 1'b0, 1'b0,
                 ssb_pkg::BLINK_PAIR_LO);
    send_request(ssb_pkg::OP_BLINK_TICK, 2'd0, 7'd0, 7'd0, 7'd0, 7'd0, 1'b0, 1'b0,
                 ssb_pkg::BLINK_NONE);
    send_request(ssb_pkg::OP_BLINK_TICK, 2'd0, 7'd0, 7'd0, 7'd0, 7'd0, 1'b0, 1'b0,
                 ssb_pkg::BLINK_NONE);
    send_request(ssb_pkg::OP_SET_BLINK, 2'd0, 7'd0, 7'd0, 7'd0, 7'd0, 1'b0, 1'b0,
                 ssb_pkg::BLINK_PAIR_LO);
    send_request(ssb_pkg::OP_SET_BLINK, 2'd0, 7'd0, 7'd0, 7'd0, 7'd0, 1'b0, 1'b0,
                 ssb_pkg::BLINK_PAIR_HI);
    send_request(ssb_pkg::OP_BLINK_TICK, 2'd0, 7'd0, 7'd0, 7'd0, 7'd0, 1'b0, 1'b0,
                 ssb_pkg::BLINK_NONE);
    send_request(ssb_pkg::OP_SET_BLINK, 2'd0, 7'd0, 7'd0, 7'd0, 7'd0, 1'b0, 1'b0,
                 ssb_pkg::BLINK_ALL);
    send_request(ssb_pkg::OP_BLINK_TICK, 2'd0, 7'd0, 7'd0, 7'd0, 7'd0, 1'b0, 1'b0,
                 ssb_pkg::BLINK_NONE);
    send_request(ssb_pkg::OP_BLINK_TICK, 2'd0, 7'd0, 7'd0, 7'd0, 7'd0, 1'b0, 1'b0,
                 ssb_pkg::BLINK_NONE);
    send_request(ssb_pkg::OP_SET_BLINK, 2'd0, 7'd0, 7'd0, 7'd0, 7'd0, 1'b0, 1'b0,
                 ssb_pkg::BLINK_NONE);
    send_request(ssb_pkg::OP_BLINK_TICK, 2'd0, 7'd0, 7'd0, 7'd0, 7'd0, 1'b0, 1'b0,
                 ssb_pkg::BLINK_NONE);
    send_request(OP_UNDEFINED, 2'd3, 7'h7f, 7'h7f, 7'h7f, 7'h7f, 1'b1, 1'b1,
                 ssb_pkg::BLINK_PAIR_HI);
    send_request(ssb_pkg::OP_ZEROS, 2'd0, 7'd0, 7'd0, 7'd0, 7'd0, 1'b1, 1'b0,
                 ssb_pkg::BLINK_NONE);
    send_request(ssb_pkg::OP_SHOW_FOUR, 2'd1, 7'h55, 7'h2a, 7'd3, 7'd7, 1'b1, 1'b0,
                 ssb_pkg::BLINK_NONE);

    // random phases, each under a new register setting; the last one runs without gaps or receiver stalls
    for (int phase = 0; phase < 4; phase++) begin
      wait_idle();
      case (phase)
        0: begin
          bright_v = 3'd0; auto_v = 8'h00; fixed_v = 8'hff;
        end
        1: begin
          bright_v = 3'd7; auto_v = 8'hff; fixed_v = 8'h00;
        end
        default: begin
          bright_v = 3'($urandom_range(0, 7));
          auto_v   = 8'($urandom_range(0, 255));
          fixed_v  = 8'($urandom_range(0, 255));
        end
      endcase
      write_reg(ssb_pkg::REG_BRIGHTNESS, {29'd0, bright_v});
      write_reg(ssb_pkg::REG_AUTO_CMD, {24'd0, auto_v});
      write_reg(ssb_pkg::REG_FIXED_CMD, {24'd0, fixed_v});
      if (phase == 3) begin
        send_gaps   = 1'b0;
        recv_stalls = 1'b0;
      end
      repeat (90) send_random_request();
    end

    wait_idle();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.expected_beats.size() == 0) begin
      $display("tb_seven_segment_blink_command_sequencer: done, clean");
    end else begin
      $display("tb_seven_segment_blink_command_sequencer: done, errors");
    end
    $finish;
  end

endmodule
